FILE: rtl/core/traffic_light_button_controller_top_defines.svh
// Assertion macros used by the traffic light controller top level.
`ifndef TRAFFIC_LIGHT_BUTTON_CONTROLLER_TOP_DEFINES_SVH
`define TRAFFIC_LIGHT_BUTTON_CONTROLLER_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define TLBC_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("tlbc same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define TLBC_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("tlbc next-cycle check failed");

`endif

FILE: rtl/core/tlbc_pkg.sv
// Types, codes and constants of the traffic light controller.
package tlbc_pkg;

  // Light phase codes
  localparam logic [2:0] PH_RED        = 3'd0;
  localparam logic [2:0] PH_RED_YELLOW = 3'd1;
  localparam logic [2:0] PH_GREEN      = 3'd2;
  localparam logic [2:0] PH_YELLOW     = 3'd3;
  localparam logic [2:0] PH_FLASH_ON   = 3'd4;
  localparam logic [2:0] PH_FLASH_OFF  = 3'd5;

  // Sleep sequence codes
  localparam logic [1:0] SL_AWAKE    = 2'd0;
  localparam logic [1:0] SL_SLEEPING = 2'd1;
  localparam logic [1:0] SL_HELD     = 2'd2;
  localparam logic [1:0] SL_SETTLE   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_RED_TICKS        = 3'd0;
  localparam logic [2:0] REG_GREEN_TICKS      = 3'd1;
  localparam logic [2:0] REG_YELLOW_TICKS     = 3'd2;
  localparam logic [2:0] REG_FLASH_TICKS      = 3'd3;
  localparam logic [2:0] REG_SLEEP_TICKS      = 3'd4;
  localparam logic [2:0] REG_LONG_PRESS_TICKS = 3'd5;

  // Press timing limits
  localparam logic [7:0]  PRESS_CAP      = 8'd250;
  localparam logic [7:0]  DEBOUNCE_TICKS = 8'd2;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [15:0] red_ticks;
    logic [15:0] green_ticks;
    logic [15:0] yellow_ticks;
    logic [15:0] flash_ticks;
    logic [15:0] sleep_ticks;
    logic [7:0]  long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  light_phase;
    logic [15:0] phase_elapsed;
    logic [7:0]  press_length;
    logic        press_active;
    logic [15:0] idle_count;
    logic [1:0]  sleep_phase;
  } state_t;

  typedef struct packed {
    logic red_on;
    logic yellow_on;
    logic green_on;
    logic asleep;
  } lamps_t;

endpackage

FILE: rtl/core/tlbc_step.sv
// Next-state and lamp logic for one tick of the traffic light controller.
module tlbc_step (
  input  tlbc_pkg::cfg_t   cfg,
  input  tlbc_pkg::state_t state,
  input  logic             button_down,
  output tlbc_pkg::state_t state_next,
  output tlbc_pkg::lamps_t lamps
);
  import tlbc_pkg::*;

  logic [7:0]  len;
  logic [15:0] elapsed;
  logic [15:0] limit;
  logic [2:0]  target;
  logic        pressed;
  logic        is_long;

  always_comb begin
    state_next = state;
    len        = state.press_length;
    elapsed    = state.phase_elapsed;
    limit      = cfg.flash_ticks;
    target     = PH_FLASH_ON;
    pressed    = 1'b0;
    is_long    = 1'b0;
    lamps      = '{red_on: 1'b0, yellow_on: 1'b0, green_on: 1'b0, asleep: 1'b1};

    case (state.sleep_phase)
      SL_SLEEPING: begin
        if (button_down) state_next.sleep_phase = SL_HELD;
      end
      SL_HELD: begin
        if (!button_down) state_next.sleep_phase = SL_SETTLE;
      end
      SL_SETTLE: begin
        state_next.sleep_phase = SL_AWAKE;
        state_next.idle_count  = '0;
        state_next.light_phase = PH_GREEN;
      end
      default: begin
        // Count the press and debounce the release
        if (state.press_active && len < PRESS_CAP) len = len + 8'd1;
        if (button_down) begin
          if (!state.press_active) begin
            state_next.press_active = 1'b1;
            len = '0;
          end
          state_next.idle_count = '0;
        end else begin
          if (state.press_active && len > DEBOUNCE_TICKS) begin
            state_next.press_active = 1'b0;
            pressed = 1'b1;
            is_long = len > cfg.long_press_ticks;
          end
          if (state.idle_count < COUNT_MAX) state_next.idle_count = state.idle_count + 16'd1;
        end
        state_next.press_length = len;

        if (elapsed < COUNT_MAX) elapsed = elapsed + 16'd1;

        // Pick dwell and successor of the current phase
        case (state.light_phase)
          PH_RED:        begin limit = cfg.red_ticks;    target = PH_RED_YELLOW; end
          PH_RED_YELLOW: begin limit = cfg.yellow_ticks; target = PH_GREEN;      end
          PH_GREEN:      begin limit = cfg.green_ticks;  target = PH_YELLOW;     end
          PH_YELLOW:     begin limit = cfg.yellow_ticks; target = PH_RED;        end
          PH_FLASH_ON:   begin limit = cfg.flash_ticks;  target = PH_FLASH_OFF;  end
          default:       begin limit = cfg.flash_ticks;  target = PH_FLASH_ON;   end
        endcase

        // A long press toggles mode, a short one cuts red or green short
        if (pressed && is_long) begin
          target = (state.light_phase < PH_FLASH_ON) ? PH_FLASH_OFF : PH_GREEN;
          limit  = '0;
        end else if (pressed &&
                     (state.light_phase == PH_RED || state.light_phase == PH_GREEN)) begin
          limit = '0;
        end

        // Advance the phase; enter sleep if idle long enough on a move to yellow or flash-off
        if (elapsed >= limit) begin
          state_next.light_phase = target;
          elapsed = '0;
          if (state_next.idle_count > cfg.sleep_ticks &&
              (target == PH_YELLOW || target == PH_FLASH_OFF)) begin
            state_next.sleep_phase = SL_SLEEPING;
          end
        end
        state_next.phase_elapsed = elapsed;

        // Drive lamps from the new phase unless asleep
        if (state_next.sleep_phase == SL_AWAKE) begin
          lamps.asleep = 1'b0;
          case (state_next.light_phase)
            PH_RED:        lamps.red_on = 1'b1;
            PH_RED_YELLOW: begin lamps.red_on = 1'b1; lamps.yellow_on = 1'b1; end
            PH_GREEN:      lamps.green_on = 1'b1;
            PH_FLASH_OFF:  lamps.yellow_on = 1'b0;
            default:       lamps.yellow_on = 1'b1;
          endcase
        end
      end
    endcase
  end

endmodule

FILE: rtl/core/traffic_light_button_controller_top.sv
// Top level of the traffic light controller with one push button.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   button_down
//   out      output     out_valid / out_stall red_on, yellow_on, green_on, asleep
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One tick word is taken per clock while in_stall is low; its lamp word is registered.
// The rate is set by the single-pass step logic between state and output register.
// A two-deep output buffer (output register plus skid) keeps input flowing
// for one more tick of output stall; in_stall rises only when both are full.
// Synchronous reset restores register defaults, state and empties the buffer.
module traffic_light_button_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        button_down,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        red_on,
  output logic        yellow_on,
  output logic        green_on,
  output logic        asleep,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tlbc_pkg::*;

`include "traffic_light_button_controller_top_defines.svh"

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  lamps_t lamps_next;
  lamps_t out_word;
  lamps_t skid_word;
  logic   skid_valid;
  logic   in_acc;
  logic   out_acc;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_ticks        <= 16'd183;
      cfg.green_ticks      <= 16'd183;
      cfg.yellow_ticks     <= 16'd37;
      cfg.flash_ticks      <= 16'd9;
      cfg.sleep_ticks      <= 16'd10986;
      cfg.long_press_ticks <= 8'd18;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RED_TICKS:        cfg.red_ticks        <= cfg_data;
        REG_GREEN_TICKS:      cfg.green_ticks      <= cfg_data;
        REG_YELLOW_TICKS:     cfg.yellow_ticks     <= cfg_data;
        REG_FLASH_TICKS:      cfg.flash_ticks      <= cfg_data;
        REG_SLEEP_TICKS:      cfg.sleep_ticks      <= cfg_data;
        REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data[7:0];
        default:              ;
      endcase
    end
  end

  tlbc_step u_step (
    .cfg         (cfg),
    .state       (state),
    .button_down (button_down),
    .state_next  (state_next),
    .lamps       (lamps_next)
  );

  // Advance controller state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state.light_phase   <= PH_GREEN;
      state.phase_elapsed <= '0;
      state.press_length  <= '0;
      state.press_active  <= 1'b0;
      state.idle_count    <= '0;
      state.sleep_phase   <= SL_AWAKE;
    end else if (in_acc) begin
      state <= state_next;
    end
  end

  // Hold results in the output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_acc && out_valid && out_stall) begin
        skid_valid <= 1'b1;
      end else if (out_acc && skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_acc) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && out_valid && out_stall) begin
      skid_word <= lamps_next;
    end else if (out_acc && skid_valid) begin
      out_word <= skid_word;
    end else if (in_acc) begin
      out_word <= lamps_next;
    end
  end

  assign red_on    = out_word.red_on;
  assign yellow_on = out_word.yellow_on;
  assign green_on  = out_word.green_on;
  assign asleep    = out_word.asleep;

  // Skid stage fills only behind a full output register
  `TLBC_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  // A pressed awake tick clears the idle count
  `TLBC_ASSERT_NEXT(a_press_clears_idle, in_acc && button_down && state.sleep_phase == SL_AWAKE,
                    state.idle_count == 16'd0)
  // Release while held moves the sleep sequence to settling
  `TLBC_ASSERT_NEXT(a_release_settles, in_acc && !button_down && state.sleep_phase == SL_HELD,
                    state.sleep_phase == SL_SETTLE)

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the traffic light controller with one push button.
module tb_top;
  import tlbc_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        button_down = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        red_on;
  logic        yellow_on;
  logic        green_on;
  logic        asleep;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_RED_TICKS;
  logic [15:0] cfg_data = 16'd0;

  traffic_light_button_controller_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .button_down (button_down),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_on      (red_on),
    .yellow_on   (yellow_on),
    .green_on    (green_on),
    .asleep      (asleep),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int MAX_REPORTS    = 40;
  localparam int TICKS_PER_SET  = 165;

  // Pending button levels and expected lamp words
  logic   tick_q[$];
  lamps_t lamp_q[$];

  // Predictor copy of the registers and the controller state
  cfg_t   regs;
  state_t ctl;

  bit in_fire, out_fire;
  int send_mode, recv_mode;
  int send_gap, stall_left, hold_left;
  int hold_reqs, holds_served;
  int quiet_cycles;
  int errors, ticks_taken, words_checked;
  int sleeps_entered, mode_toggles, quick_ends, settings_run;

  // Work out the lamp word for one tick and advance the predicted state
  function automatic lamps_t advance_tick(input logic down);
    logic [7:0]  len;
    logic [15:0] elapsed;
    logic [15:0] limit;
    logic [2:0]  target;
    logic        counted;
    logic        is_long;
    lamps_t      lit;
    counted = 1'b0;
    is_long = 1'b0;
    lit = '0;
    lit.asleep = 1'b1;

    // Sleep sequence: lamps dark, no press or phase timer touched
    if (ctl.sleep_phase == SL_SLEEPING) begin
      if (down) ctl.sleep_phase = SL_HELD;
      return lit;
    end
    if (ctl.sleep_phase == SL_HELD) begin
      if (!down) ctl.sleep_phase = SL_SETTLE;
      return lit;
    end
    if (ctl.sleep_phase == SL_SETTLE) begin
      ctl.sleep_phase = SL_AWAKE;
      ctl.idle_count = 16'd0;
      ctl.light_phase = PH_GREEN;
      return lit;
    end

    // Debounce the button and time the press
    len = ctl.press_length;
    if (ctl.press_active && len < PRESS_CAP) len++;
    if (down) begin
      if (!ctl.press_active) begin
        ctl.press_active = 1'b1;
        len = 8'd0;
      end
      ctl.idle_count = 16'd0;
    end else begin
      if (ctl.press_active && len > DEBOUNCE_TICKS) begin
        ctl.press_active = 1'b0;
        counted = 1'b1;
        is_long = len > regs.long_press_ticks;
      end
      if (ctl.idle_count < COUNT_MAX) ctl.idle_count++;
    end
    ctl.press_length = len;

    elapsed = ctl.phase_elapsed;
    if (elapsed < COUNT_MAX) elapsed++;

    // Pick dwell and successor of the current phase
    case (ctl.light_phase)
      PH_RED: begin
        limit = regs.red_ticks;
        target = PH_RED_YELLOW;
      end
      PH_RED_YELLOW: begin
        limit = regs.yellow_ticks;
        target = PH_GREEN;
      end
      PH_GREEN: begin
        limit = regs.green_ticks;
        target = PH_YELLOW;
      end
      PH_YELLOW: begin
        limit = regs.yellow_ticks;
        target = PH_RED;
      end
      PH_FLASH_ON: begin
        limit = regs.flash_ticks;
        target = PH_FLASH_OFF;
      end
      default: begin
        limit = regs.flash_ticks;
        target = PH_FLASH_ON;
      end
    endcase

    // A long press toggles the mode, a short one cuts red or green short
    if (counted && is_long) begin
      target = (ctl.light_phase < PH_FLASH_ON) ? PH_FLASH_OFF : PH_GREEN;
      limit = 16'd0;
      mode_toggles++;
    end else if (counted && (ctl.light_phase == PH_RED || ctl.light_phase == PH_GREEN)) begin
      limit = 16'd0;
      quick_ends++;
    end

    if (elapsed >= limit) begin
      ctl.light_phase = target;
      elapsed = 16'd0;
      if (ctl.idle_count > regs.sleep_ticks &&
          (target == PH_YELLOW || target == PH_FLASH_OFF)) begin
        ctl.sleep_phase = SL_SLEEPING;
        sleeps_entered++;
      end
    end
    ctl.phase_elapsed = elapsed;

    if (ctl.sleep_phase == SL_SLEEPING) return lit;

    // Drive the lamps from the phase
    lit = '0;
    case (ctl.light_phase)
      PH_RED: lit.red_on = 1'b1;
      PH_RED_YELLOW: begin
        lit.red_on = 1'b1;
        lit.yellow_on = 1'b1;
      end
      PH_GREEN: lit.green_on = 1'b1;
      PH_FLASH_OFF: ;
      default: lit.yellow_on = 1'b1;
    endcase
    return lit;
  endfunction

  // Cycles one side waits before its next word
  function automatic int draw_wait(input int mode);
    if (mode == 1) return $urandom_range(0, 17);
    if (mode == 2) return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    return 0;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check delivered lamp words, predict accepted ticks, watch for a hang
  always @(posedge clk) begin
    lamps_t want;
    in_fire = 1'b0;
    out_fire = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        out_fire = 1'b1;
        if (lamp_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: lamp word with none expected: r%0b y%0b g%0b s%0b",
                     $time, red_on, yellow_on, green_on, asleep);
        end else begin
          want = lamp_q.pop_front();
          words_checked++;
          if (want.red_on !== red_on || want.yellow_on !== yellow_on ||
              want.green_on !== green_on || want.asleep !== asleep) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: lamp word %0d expected r%0b y%0b g%0b s%0b, got r%0b y%0b g%0b s%0b",
                       $time, words_checked, want.red_on, want.yellow_on, want.green_on,
                       want.asleep, red_on, yellow_on, green_on, asleep);
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        ticks_taken++;
        lamp_q.push_back(advance_tick(button_down));
      end
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d lamp words outstanding",
                 $time, quiet_cycles, lamp_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer pending ticks, pausing a random number of cycles after each
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_fire) send_gap = draw_wait(send_mode);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        in_valid <= 1'b1;
        button_down <= tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the lamp side at random, with an occasional long hold
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_reqs != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (out_fire) stall_left = draw_wait(recv_mode);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_RED_TICKS:        regs.red_ticks = val;
      REG_GREEN_TICKS:      regs.green_ticks = val;
      REG_YELLOW_TICKS:     regs.yellow_ticks = val;
      REG_FLASH_TICKS:      regs.flash_ticks = val;
      REG_SLEEP_TICKS:      regs.sleep_ticks = val;
      REG_LONG_PRESS_TICKS: regs.long_press_ticks = val[7:0];
      default: ;
    endcase
  endtask

  // Load a full timing setting while the block is idle
  task automatic program_timing(input logic [15:0] red, input logic [15:0] green,
                                input logic [15:0] yellow, input logic [15:0] flash,
                                input logic [15:0] sleep, input logic [7:0] long_press);
    write_reg(REG_RED_TICKS, red);
    write_reg(REG_GREEN_TICKS, green);
    write_reg(REG_YELLOW_TICKS, yellow);
    write_reg(REG_FLASH_TICKS, flash);
    write_reg(REG_SLEEP_TICKS, sleep);
    write_reg(REG_LONG_PRESS_TICKS, {8'd0, long_press});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every tick is taken and every lamp word has come back
  task automatic wait_drained();
    while (tick_q.size() > 0 || in_valid || lamp_q.size() > 0) @(posedge clk);
  endtask

  // Queue a rest, then a bounce, short, long or saturating press, or noise
  task automatic queue_gesture();
    int lp;
    int pick;
    int hold;
    lp = int'(regs.long_press_ticks);
    pick = $urandom_range(0, 99);
    repeat ((pick < 20) ? $urandom_range(30, 140) : $urandom_range(0, 12))
      tick_q.push_back(1'b0);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(4, 24)) tick_q.push_back(1'($urandom_range(0, 1)));
      return;
    end
    if (pick < 25) hold = $urandom_range(1, 2);
    else if (pick < 65) hold = $urandom_range(3, (lp < 3) ? 3 : ((lp > 40) ? 40 : lp));
    else if (lp >= 240) hold = $urandom_range(245, 270);
    else hold = lp + 1 + $urandom_range(0, 20);
    repeat (hold) tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
  endtask

  // Stimulus: directed opening, then random gestures under several settings
  initial begin
    int p;
    int base;
    regs.red_ticks = 16'd183;
    regs.green_ticks = 16'd183;
    regs.yellow_ticks = 16'd37;
    regs.flash_ticks = 16'd9;
    regs.sleep_ticks = 16'd10986;
    regs.long_press_ticks = 8'd18;
    ctl = '0;
    ctl.light_phase = PH_GREEN;
    ctl.sleep_phase = SL_AWAKE;
    send_mode = 0;
    recv_mode = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a one-tick press that still ends green early, then a long press into flash
    send_mode = 2;
    recv_mode = 2;
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);
    repeat (3) tick_q.push_back(1'b0);
    repeat (19) tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    settings_run = 1;

    for (p = 0; p < 10; p++) begin
      wait_drained();
      case (p)
        0: ;
        1: program_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
        2: program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        3: program_timing(16'd3, 16'd4, 16'd2, 16'd5, 16'd40, 8'd10);
        4: program_timing(16'd1, 16'd2, 16'd1, 16'd1, 16'd20, 8'd3);
        5: program_timing(16'd6, 16'd5, 16'd3, 16'd2, 16'd60, 8'd249);
        default: program_timing(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                                16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                                16'($urandom_range(0, 80)), 8'($urandom_range(0, 40)));
      endcase
      if (p > 0) settings_run++;
      send_mode = (p == 2) ? 0 : $urandom_range(0, 2);
      recv_mode = (p == 2) ? 2 : $urandom_range(0, 2);
      base = tick_q.size();
      while (tick_q.size() - base < TICKS_PER_SET) queue_gesture();
      // Long receiver hold while ticks keep coming, so the block backs up
      if (p == 2) hold_reqs++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Ran %0d ticks and checked %0d lamp words across %0d timing settings.",
             ticks_taken, words_checked, settings_run);
    $display("Saw %0d deep sleeps, %0d mode toggles and %0d early ends of red or green.",
             sleeps_entered, mode_toggles, quick_ends);
    if (errors == 0 && lamp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: traffic_light_button_controller_top.f
+incdir+rtl/core
rtl/core/tlbc_pkg.sv
rtl/core/tlbc_step.sv
rtl/core/traffic_light_button_controller_top.sv
bench/tb_top.sv
